FILE: hw/rtl/sit_pkg.sv
// Shared types and codes for the segment intersection test.
package sit_pkg;

    // Query kinds carried in the func field.
    localparam logic FUNC_SEG  = 1'b0;
    localparam logic FUNC_RECT = 1'b1;

    // Load enables for the pipeline stages, one per register rank.
    typedef struct packed {
        logic in_ld;
        logic diff_ld;
        logic prod_ld;
        logic out_ld;
    } t_pipe_en;

endpackage

FILE: hw/rtl/sit_pipe_ctl.sv
// Valid tracking and stall chain for the four-rank test pipeline.
module sit_pipe_ctl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stall,
    output logic              o_stall,
    output logic              o_valid,
    output sit_pkg::t_pipe_en o_en
);

    logic r_v_in;
    logic r_v_diff;
    logic r_v_prod;
    logic r_v_out;
    logic n_v_in;
    logic n_v_diff;
    logic n_v_prod;
    logic n_v_out;
    logic free_in;
    logic free_diff;
    logic free_prod;
    logic free_out;

    // A rank may load when it is empty or when its word moves on this cycle,
    // so bubbles are squeezed out rather than stalling the whole pipeline.
    always_comb begin
        free_out  = !r_v_out  || !i_stall;
        free_prod = !r_v_prod || free_out;
        free_diff = !r_v_diff || free_prod;
        free_in   = !r_v_in   || free_diff;

        n_v_in   = free_in   ? i_valid  : r_v_in;
        n_v_diff = free_diff ? r_v_in   : r_v_diff;
        n_v_prod = free_prod ? r_v_diff : r_v_prod;
        n_v_out  = free_out  ? r_v_prod : r_v_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in   <= 1'b0;
            r_v_diff <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            r_v_in   <= n_v_in;
            r_v_diff <= n_v_diff;
            r_v_prod <= n_v_prod;
            r_v_out  <= n_v_out;
        end
    end

    assign o_stall        = !free_in;
    assign o_valid        = r_v_out;
    assign o_en.in_ld     = free_in;
    assign o_en.diff_ld   = free_diff;
    assign o_en.prod_ld   = free_prod;
    assign o_en.out_ld    = free_out;

endmodule

FILE: hw/rtl/sit_cross.sv
// One segment pair crossing unit: registered differences, registered products, range check.
module sit_cross #(
    parameter int COORD_BITS = 16
) (
    input  logic                    i_clk,
    input  sit_pkg::t_pipe_en       i_en,
    input  logic signed [COORD_BITS:0] i_x1,
    input  logic signed [COORD_BITS:0] i_y1,
    input  logic signed [COORD_BITS:0] i_x2,
    input  logic signed [COORD_BITS:0] i_y2,
    input  logic signed [COORD_BITS:0] i_x3,
    input  logic signed [COORD_BITS:0] i_y3,
    input  logic signed [COORD_BITS:0] i_x4,
    input  logic signed [COORD_BITS:0] i_y4,
    output logic                    o_hit
);

    localparam int DW = COORD_BITS + 2;
    localparam int PW = 2 * COORD_BITS + 4;
    localparam int SW = 2 * COORD_BITS + 5;

    logic signed [DW-1:0] r_dx12;
    logic signed [DW-1:0] r_dy12;
    logic signed [DW-1:0] r_dx34;
    logic signed [DW-1:0] r_dy34;
    logic signed [DW-1:0] r_dx13;
    logic signed [DW-1:0] r_dy13;
    logic signed [PW-1:0] r_p_den0;
    logic signed [PW-1:0] r_p_den1;
    logic signed [PW-1:0] r_p_na0;
    logic signed [PW-1:0] r_p_na1;
    logic signed [PW-1:0] r_p_nb0;
    logic signed [PW-1:0] r_p_nb1;
    logic signed [SW-1:0] den;
    logic signed [SW-1:0] na;
    logic signed [SW-1:0] nb;
    logic                 na_ok;
    logic                 nb_ok;

    always_ff @(posedge i_clk) begin
        if (i_en.diff_ld) begin
            r_dx12 <= DW'(i_x2) - DW'(i_x1);
            r_dy12 <= DW'(i_y2) - DW'(i_y1);
            r_dx34 <= DW'(i_x4) - DW'(i_x3);
            r_dy34 <= DW'(i_y4) - DW'(i_y3);
            r_dx13 <= DW'(i_x1) - DW'(i_x3);
            r_dy13 <= DW'(i_y1) - DW'(i_y3);
        end
        if (i_en.prod_ld) begin
            r_p_den0 <= PW'(r_dy34) * PW'(r_dx12);
            r_p_den1 <= PW'(r_dx34) * PW'(r_dy12);
            r_p_na0  <= PW'(r_dx34) * PW'(r_dy13);
            r_p_na1  <= PW'(r_dy34) * PW'(r_dx13);
            r_p_nb0  <= PW'(r_dx12) * PW'(r_dy13);
            r_p_nb1  <= PW'(r_dy12) * PW'(r_dx13);
        end
    end

    // Both parameters lie in the closed unit range when each numerator has the
    // sign of the denominator and no greater magnitude. Parallel pairs never hit.
    always_comb begin
        den = SW'(r_p_den0) - SW'(r_p_den1);
        na  = SW'(r_p_na0) - SW'(r_p_na1);
        nb  = SW'(r_p_nb0) - SW'(r_p_nb1);
        if (den > 0) begin
            na_ok = (na >= 0) && (na <= den);
            nb_ok = (nb >= 0) && (nb <= den);
        end else begin
            na_ok = (na <= 0) && (na >= den);
            nb_ok = (nb <= 0) && (nb >= den);
        end
        o_hit = (den != 0) && na_ok && nb_ok;
    end

endmodule

FILE: hw/rtl/segment_intersection_test.sv
// Top level of the segment intersection test: input rank, four crossing units, result rank.
// A word moves through the input, difference, product and result ranks to its hit flag.
// One word per cycle unless stalled; each rank advances independently and bubbles close up.
// Reset (synchronous, active low) empties all ranks; payload registers are not cleared.
// The stall towards the sender follows the downstream stall only when every rank is full.
module segment_intersection_test #(
    parameter int COORD_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_func,
    input  logic signed [COORD_BITS-1:0] i_seg_ax,
    input  logic signed [COORD_BITS-1:0] i_seg_ay,
    input  logic signed [COORD_BITS-1:0] i_seg_bx,
    input  logic signed [COORD_BITS-1:0] i_seg_by,
    input  logic signed [COORD_BITS-1:0] i_c_x,
    input  logic signed [COORD_BITS-1:0] i_c_y,
    input  logic signed [COORD_BITS-1:0] i_d_x,
    input  logic signed [COORD_BITS-1:0] i_d_y,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_hit
);

    localparam int EW = COORD_BITS + 1;

    sit_pkg::t_pipe_en en;

    // Input rank: the word as it arrived.
    logic                        r_func;
    logic signed [COORD_BITS-1:0] r_ax;
    logic signed [COORD_BITS-1:0] r_ay;
    logic signed [COORD_BITS-1:0] r_bx;
    logic signed [COORD_BITS-1:0] r_by;
    logic signed [COORD_BITS-1:0] r_cx;
    logic signed [COORD_BITS-1:0] r_cy;
    logic signed [COORD_BITS-1:0] r_dx;
    logic signed [COORD_BITS-1:0] r_dy;

    // The query kind follows its word down through the difference and product ranks.
    logic r_func_diff;
    logic r_func_prod;
    logic r_hit;
    logic n_hit;

    // Coordinates widened by one bit so that the far rectangle corner fits.
    logic signed [EW-1:0] ax;
    logic signed [EW-1:0] ay;
    logic signed [EW-1:0] bx;
    logic signed [EW-1:0] by;
    logic signed [EW-1:0] rect_l;
    logic signed [EW-1:0] rect_t;
    logic signed [EW-1:0] rect_r;
    logic signed [EW-1:0] rect_b;
    logic signed [EW-1:0] u0_x3;
    logic signed [EW-1:0] u0_y3;
    logic signed [EW-1:0] u0_x4;
    logic signed [EW-1:0] u0_y4;
    logic                 is_rect;
    logic                 hit_top;
    logic                 hit_right;
    logic                 hit_bottom;
    logic                 hit_left;

    sit_pipe_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_en    (en)
    );

    always_ff @(posedge i_clk) begin
        if (en.in_ld) begin
            r_func <= i_func;
            r_ax   <= i_seg_ax;
            r_ay   <= i_seg_ay;
            r_bx   <= i_seg_bx;
            r_by   <= i_seg_by;
            r_cx   <= i_c_x;
            r_cy   <= i_c_y;
            r_dx   <= i_d_x;
            r_dy   <= i_d_y;
        end
        if (en.diff_ld) begin
            r_func_diff <= r_func;
        end
        if (en.prod_ld) begin
            r_func_prod <= r_func_diff;
        end
        if (en.out_ld) begin
            r_hit <= n_hit;
        end
    end

    // The rectangle corners are formed as given, so a negative width or height
    // simply mirrors the rectangle; an edge of zero length never reports a hit.
    always_comb begin
        is_rect = (r_func == sit_pkg::FUNC_RECT);
        ax      = EW'(r_ax);
        ay      = EW'(r_ay);
        bx      = EW'(r_bx);
        by      = EW'(r_by);
        rect_l  = EW'(r_cx);
        rect_t  = EW'(r_cy);
        rect_r  = EW'(r_cx) + EW'(r_dx);
        rect_b  = EW'(r_cy) + EW'(r_dy);

        // The first unit serves the second segment, or the top edge of a rectangle.
        if (is_rect) begin
            u0_x3 = rect_l;
            u0_y3 = rect_t;
            u0_x4 = rect_r;
            u0_y4 = rect_t;
        end else begin
            u0_x3 = EW'(r_cx);
            u0_y3 = EW'(r_cy);
            u0_x4 = EW'(r_dx);
            u0_y4 = EW'(r_dy);
        end
    end

    sit_cross #(.COORD_BITS(COORD_BITS)) u_cross_top (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x1  (ax),
        .i_y1  (ay),
        .i_x2  (bx),
        .i_y2  (by),
        .i_x3  (u0_x3),
        .i_y3  (u0_y3),
        .i_x4  (u0_x4),
        .i_y4  (u0_y4),
        .o_hit (hit_top)
    );

    sit_cross #(.COORD_BITS(COORD_BITS)) u_cross_right (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x1  (ax),
        .i_y1  (ay),
        .i_x2  (bx),
        .i_y2  (by),
        .i_x3  (rect_r),
        .i_y3  (rect_t),
        .i_x4  (rect_r),
        .i_y4  (rect_b),
        .o_hit (hit_right)
    );

    sit_cross #(.COORD_BITS(COORD_BITS)) u_cross_bottom (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x1  (ax),
        .i_y1  (ay),
        .i_x2  (bx),
        .i_y2  (by),
        .i_x3  (rect_r),
        .i_y3  (rect_b),
        .i_x4  (rect_l),
        .i_y4  (rect_b),
        .o_hit (hit_bottom)
    );

    sit_cross #(.COORD_BITS(COORD_BITS)) u_cross_left (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x1  (ax),
        .i_y1  (ay),
        .i_x2  (bx),
        .i_y2  (by),
        .i_x3  (rect_l),
        .i_y3  (rect_b),
        .i_x4  (rect_l),
        .i_y4  (rect_t),
        .o_hit (hit_left)
    );

    // The right, bottom and left edges only matter for a rectangle query. A segment lying
    // wholly inside the rectangle crosses no edge and is therefore a miss.
    always_comb begin
        n_hit = hit_top;
        if (r_func_prod == sit_pkg::FUNC_RECT) begin
            n_hit = hit_top || hit_right || hit_bottom || hit_left;
        end
    end

    assign o_hit = r_hit;

endmodule
